// ----- src/vps_pkg.sv -----
// ----------------------------------------------------------------------------
// vps_pkg: shared types and constants of the visibility pyramid score block
// Holds the beat types of both channels, the register map and the state
// machine encodings used by the front and back parts.
// ----------------------------------------------------------------------------
package vps_pkg;

    localparam int POS_W    = 16;
    localparam int EXTENT_W = 13;
    localparam int SCORE_W  = 25;
    localparam int DIV_W    = EXTENT_W + 4;

    localparam logic [EXTENT_W-1:0] EXTENT_RESET = 13'd4096;

    // Register indexes, taken from paddr[2].
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Request commands.
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic             command;
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
    } vps_req_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               range_error;
    } vps_rsp_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIVIDE,
        FRONT_PUSH
    } vps_front_state_t;

    typedef enum logic [2:0] {
        BACK_CLEAR,
        BACK_IDLE,
        BACK_READ,
        BACK_UPDATE,
        BACK_RESULT
    } vps_back_state_t;

endpackage

// ----- src/visibility_pyramid_score.sv -----
// ----------------------------------------------------------------------------
// visibility_pyramid_score: coverage score of a cell pyramid over an image
// Tracks how many cells of a multi-level grid hold at least one point and
// returns the running score after every add or remove request.
// ----------------------------------------------------------------------------
// Usage:
// A request beat (command, x_pos, y_pos) enters on the req channel and is
// taken at a rising edge with req_valid high and req_stall low. Every request
// gives exactly one response beat (score, range_error) on the rsp channel,
// taken when rsp_valid is high and rsp_stall is low.
// The front part maps the point to a cell of the finest grid with two
// restoring dividers, one quotient bit per cycle. The back part does one
// read-modify-write of the counter memory per level, a read state and then
// an update state, since the memory has a registered read port. It takes no
// new request until it has passed on the score of the last one; the front
// part maps the next request meanwhile. After reset the counter memory,
// (4^(LEVELS+1) - 4)/3 entries (5460 at LEVELS = 6), is swept to zero, one
// entry per cycle; req_stall stays high until the sweep is done.
// Registers may be written during the sweep. A stalled response holds in
// the output register; the back part then waits with its finished score
// and the queue in front of it fills up.
// ----------------------------------------------------------------------------
module visibility_pyramid_score
    import vps_pkg::*;
#(
    parameter int LEVELS     = 6,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  vps_req_t    req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output vps_rsp_t    rsp
);

    logic [EXTENT_W-1:0] image_width_reg;
    logic [EXTENT_W-1:0] image_height_reg;
    logic                cfg_write;

    logic              clearing;
    logic              front_valid, front_stall;
    logic [2*LEVELS:0] front_data;
    logic              back_valid, back_stall;
    logic [2*LEVELS:0] back_data;

    // Register file. Both registers sit in 32-bit words; paddr[2] picks the
    // word and the low address bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= EXTENT_RESET;
            image_height_reg <= EXTENT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_IMAGE_WIDTH)
            begin
                image_width_reg <= pwdata[EXTENT_W-1:0];
            end
            else
            begin
                image_height_reg <= pwdata[EXTENT_W-1:0];
            end
        end
    end

    // Front part: request intake and division to a finest-grid cell.
    vps_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .clearing     (clearing),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .cell_valid   (front_valid),
        .cell_stall   (front_stall),
        .cell_data    (front_data)
    );

    // Mapped cells wait here so that either side can stall on its own.
    vps_queue #(
        .WIDTH (2 * LEVELS + 1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_stall (front_stall),
        .push_data  (front_data),
        .pop_valid  (back_valid),
        .pop_stall  (back_stall),
        .pop_data   (back_data)
    );

    // Back part: per-level counter updates, the running score and the
    // response register.
    vps_back #(
        .LEVELS     (LEVELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clearing   (clearing),
        .cell_valid (back_valid),
        .cell_stall (back_stall),
        .cell_data  (back_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

// ----- src/vps_ram.sv -----
// ----------------------------------------------------------------------------
// vps_ram: generic single-write, single-read memory
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module vps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/vps_front.sv -----
// ----------------------------------------------------------------------------
// vps_front: request intake and cell mapping
// Accepts a request beat and maps both coordinates to a cell of the finest
// grid with two restoring dividers, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vps_front
    import vps_pkg::*;
#(
    parameter int LEVELS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clearing,
    input  logic [EXTENT_W-1:0]   image_width,
    input  logic [EXTENT_W-1:0]   image_height,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  vps_req_t              req,
    output logic                  cell_valid,
    input  logic                  cell_stall,
    output logic [2*LEVELS:0]     cell_data
);

    localparam int STEP_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LEVELS - 1);

    vps_front_state_t state_reg, state_next;

    logic              cmd_reg;
    logic [DIV_W-1:0]  div_x_reg, div_y_reg;
    logic [DIV_W-1:0]  rem_x_reg, rem_y_reg;
    logic [LEVELS-1:0] quo_x_reg, quo_y_reg;
    logic              top_x_reg, top_y_reg;
    logic [STEP_W-1:0] step_reg;

    logic              accept;
    logic [DIV_W-1:0]  div_x_in, div_y_in;
    logic [DIV_W:0]    dbl_x, dbl_y;
    logic              ge_x, ge_y;
    logic [LEVELS-1:0] cell_x, cell_y;

    assign accept   = req_valid && !req_stall;
    assign div_x_in = {image_width, 4'b0000};
    assign div_y_in = {image_height, 4'b0000};

    // One restoring step per axis: a remainder below the divisor stays below it.
    assign dbl_x = {rem_x_reg, 1'b0};
    assign dbl_y = {rem_y_reg, 1'b0};
    assign ge_x  = dbl_x >= {1'b0, div_x_reg};
    assign ge_y  = dbl_y >= {1'b0, div_y_reg};

    // A quotient of 2^LEVELS or more, or a zero extent, lands on the top cell.
    assign cell_x = top_x_reg ? {LEVELS{1'b1}} : quo_x_reg;
    assign cell_y = top_y_reg ? {LEVELS{1'b1}} : quo_y_reg;
    assign cell_data = {cmd_reg, cell_y, cell_x};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FRONT_IDLE:
            begin
                if (accept)
                begin
                    state_next = FRONT_DIVIDE;
                end
            end
            FRONT_DIVIDE:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH:
            begin
                if (!cell_stall)
                begin
                    state_next = FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall  = 1'b1;
        cell_valid = 1'b0;
        case (state_reg)
            FRONT_IDLE:
            begin
                req_stall = clearing;
            end
            FRONT_PUSH:
            begin
                cell_valid = 1'b1;
            end
            default:
            begin
                req_stall  = 1'b1;
                cell_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.command;
            div_x_reg <= div_x_in;
            div_y_reg <= div_y_in;
            rem_x_reg <= DIV_W'(req.x_pos);
            rem_y_reg <= DIV_W'(req.y_pos);
            top_x_reg <= (image_width == '0) || ({1'b0, req.x_pos} >= div_x_in);
            top_y_reg <= (image_height == '0) || ({1'b0, req.y_pos} >= div_y_in);
            quo_x_reg <= '0;
            quo_y_reg <= '0;
            step_reg  <= '0;
        end
        else if (state_reg == FRONT_DIVIDE)
        begin
            rem_x_reg <= ge_x ? DIV_W'(dbl_x - {1'b0, div_x_reg}) : DIV_W'(dbl_x);
            rem_y_reg <= ge_y ? DIV_W'(dbl_y - {1'b0, div_y_reg}) : DIV_W'(dbl_y);
            quo_x_reg <= LEVELS'({quo_x_reg, ge_x});
            quo_y_reg <= LEVELS'({quo_y_reg, ge_y});
            step_reg  <= step_reg + 1'b1;
        end
    end

endmodule

// ----- src/vps_queue.sv -----
// ----------------------------------------------------------------------------
// vps_queue: two-entry queue between the front and back parts
// Lets the front part map the next request while the back part is still
// walking the levels of the previous one.
// ----------------------------------------------------------------------------
module vps_queue #(
    parameter int WIDTH = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_stall,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_stall,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign push_stall = (count_reg == 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/vps_back.sv -----
// ----------------------------------------------------------------------------
// vps_back: level walker and score keeper
// Clears the counter memory after reset, then for each mapped request does
// one read-modify-write per level, finest first, and issues the score beat.
// ----------------------------------------------------------------------------
module vps_back
    import vps_pkg::*;
#(
    parameter int LEVELS     = 6,
    parameter int COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    output logic              clearing,
    input  logic              cell_valid,
    output logic              cell_stall,
    input  logic [2*LEVELS:0] cell_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output vps_rsp_t          rsp
);

    localparam int TOTAL_CELLS = ((1 << (2 * LEVELS + 2)) - 4) / 3;
    localparam int ADDR_W      = $clog2(TOTAL_CELLS);
    localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL_CELLS - 1);
    localparam logic [LVL_W-1:0]  TOP_LEVEL = LVL_W'(LEVELS - 1);

    // First address of a level: the cells of all coarser levels come first.
    function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
        logic [ADDR_W-1:0] base;
        base = '0;
        for (int k = 0; k < LEVELS - 1; k++)
        begin
            if (LVL_W'(k) < lvl)
            begin
                base = base | (ADDR_W'(1) << (2 * k + 2));
            end
        end
        return base;
    endfunction

    vps_back_state_t state_reg, state_next;

    logic [ADDR_W-1:0]  clr_addr_reg;
    logic               cmd_reg;
    logic [LEVELS-1:0]  cx_reg, cy_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic               err_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               rsp_valid_reg;
    vps_rsp_t           rsp_reg;

    logic                  pop;
    logic                  load_rsp;
    logic [ADDR_W-1:0]     cell_addr;
    logic [LVL_W:0]        row_shift;
    logic [COUNT_BITS-1:0] count_rd, count_wr;
    logic                  count_full, count_zero, count_one;
    logic                  count_bad;
    logic [SCORE_W-1:0]    level_cells;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;

    assign pop      = cell_valid && !cell_stall;
    assign load_rsp = (state_reg == BACK_RESULT) && (!rsp_valid_reg || !rsp_stall);

    assign row_shift = {1'b0, lvl_reg} + 1'b1;
    assign cell_addr = level_base(lvl_reg)
                     + ((ADDR_W'(cy_reg) << row_shift) | ADDR_W'(cx_reg));

    assign level_cells = SCORE_W'(1) << {row_shift, 1'b0};

    assign count_full = (count_rd == {COUNT_BITS{1'b1}});
    assign count_zero = (count_rd == '0);
    assign count_one  = (count_rd == COUNT_BITS'(1));
    assign count_bad  = (cmd_reg == CMD_ADD) ? count_full : count_zero;
    assign count_wr   = (cmd_reg == CMD_ADD) ? count_rd + 1'b1 : count_rd - 1'b1;

    assign ram_we    = (state_reg == BACK_CLEAR) || ((state_reg == BACK_UPDATE) && !count_bad);
    assign ram_waddr = (state_reg == BACK_CLEAR) ? clr_addr_reg : cell_addr;

    vps_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TOTAL_CELLS)
    ) u_counters (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ((state_reg == BACK_CLEAR) ? '0 : count_wr),
        .raddr (cell_addr),
        .rdata (count_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = BACK_IDLE;
                end
            end
            BACK_IDLE:
            begin
                if (pop)
                begin
                    state_next = BACK_READ;
                end
            end
            BACK_READ:
            begin
                state_next = BACK_UPDATE;
            end
            BACK_UPDATE:
            begin
                state_next = (lvl_reg == '0) ? BACK_RESULT : BACK_READ;
            end
            BACK_RESULT:
            begin
                if (load_rsp)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clearing   = 1'b0;
        cell_stall = 1'b1;
        case (state_reg)
            BACK_CLEAR:
            begin
                clearing = 1'b1;
            end
            BACK_IDLE:
            begin
                cell_stall = 1'b0;
            end
            default:
            begin
                clearing   = 1'b0;
                cell_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_CLEAR;
            clr_addr_reg  <= '0;
            score_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BACK_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if ((state_reg == BACK_UPDATE) && !count_bad)
            begin
                if ((cmd_reg == CMD_ADD) && count_zero)
                begin
                    score_reg <= score_reg + level_cells;
                end
                else if ((cmd_reg == CMD_REMOVE) && count_one)
                begin
                    score_reg <= score_reg - level_cells;
                end
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= cell_data[2*LEVELS];
            cy_reg  <= cell_data[2*LEVELS-1:LEVELS];
            cx_reg  <= cell_data[LEVELS-1:0];
            lvl_reg <= TOP_LEVEL;
            err_reg <= 1'b0;
        end
        else if (state_reg == BACK_UPDATE)
        begin
            cx_reg  <= cx_reg >> 1;
            cy_reg  <= cy_reg >> 1;
            lvl_reg <= lvl_reg - 1'b1;
            err_reg <= err_reg | count_bad;
        end
        if (load_rsp)
        begin
            rsp_reg.score       <= score_reg;
            rsp_reg.range_error <= err_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- tb/tb_visibility_pyramid_score.sv -----
// ----------------------------------------------------------------------------
// tb_visibility_pyramid_score: self-checking bench for the pyramid score block
// Streams add and remove requests through the block under several image
// sizes, predicts every response with a bit-true model of the cell pyramid
// and compares score and range flag beat by beat. Random gaps on both sides
// and one long response hold-off are included.
// ----------------------------------------------------------------------------
module tb_visibility_pyramid_score;
    import vps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS      = 6;
    localparam int COUNT_BITS  = 16;
    localparam int FINE_DIM    = 1 << LEVELS;
    localparam int TOTAL_CELLS = ((1 << (2 * LEVELS + 2)) - 4) / 3;
    localparam int CLK_PERIOD  = 2;

    localparam bit [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [31:0] EXTENT_MASK = (32'd1 << EXTENT_W) - 1;

    // A correct run stays well below the limit even with the longest gaps
    // and stalls on every beat.
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned HOLD_CYCLES  = 900;
    localparam int unsigned TAIL_CYCLES  = 64;
    localparam int unsigned PHASE_ITEMS  = 125;
    localparam int unsigned LIVE_MAX     = 48;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals that the bench drives. Every input of the
    // block starts from a known value at time zero.
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid = 1'b0;
    logic        req_stall;
    vps_req_t    req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    vps_rsp_t    rsp;

    always #(CLK_PERIOD / 2) clk = ~clk;

    visibility_pyramid_score dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // Shadow state of the pyramid. The counters are two-state and therefore
    // start at zero, which matches the cleared memory after the reset sweep.
    // ------------------------------------------------------------------------
    bit [COUNT_BITS-1:0] cell_count [TOTAL_CELLS];
    bit [SCORE_W-1:0]    score_model  = '0;
    bit [EXTENT_W-1:0]   width_model  = EXTENT_RESET;
    bit [EXTENT_W-1:0]   height_model = EXTENT_RESET;

    vps_req_t request_queue [$];   // requests waiting for the driver
    vps_rsp_t score_expect  [$];   // predicted responses, oldest first
    vps_req_t live_points   [$];   // points added and not yet removed

    int unsigned error_count     = 0;
    int unsigned cfg_error_count = 0;
    int unsigned cycle_count     = 0;

    // Flow controls owned by the stimulus process.
    bit steady_flow     = 1'b0;    // no gaps and no random stalls
    bit backlog_request = 1'b0;    // asks the receiver for one long hold-off

    // Owned by the driver and the monitor respectively.
    int unsigned gap_left        = 0;
    int unsigned stall_left      = 0;
    int unsigned hold_left       = 0;
    bit          backlog_started = 1'b0;

    // Mostly short idle stretches, a few long ones.
    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Finest-grid cell on one axis: floor(2^LEVELS * pos / (16 * extent)),
    // clipped to the top cell. A zero extent behaves like an infinite
    // quotient and lands on the top cell as well.
    function automatic int unsigned fine_cell(logic [POS_W-1:0] pos,
                                              logic [EXTENT_W-1:0] extent);
        longint unsigned q;
        if (extent == '0)
            return FINE_DIM - 1;
        q = (longint'(pos) << LEVELS) / (longint'(extent) * 16);
        if (q > FINE_DIM - 1)
            return FINE_DIM - 1;
        return int'(q);
    endfunction

    // Applies one accepted request to the shadow pyramid and queues the
    // response that the block must give for it. Levels are walked from the
    // finest grid down to the 2 by 2 grid; a level whose counter would leave
    // its range keeps its value and only raises the flag.
    function automatic void predict_score(vps_req_t item);
        int unsigned cx;
        int unsigned cy;
        int unsigned dim;
        int unsigned base;
        int unsigned idx;
        int          lvl;
        bit          saturated;
        vps_rsp_t    outcome;
        cx = fine_cell(item.x_pos, width_model);
        cy = fine_cell(item.y_pos, height_model);
        saturated = 1'b0;
        for (lvl = LEVELS - 1; lvl >= 0; lvl--)
        begin
            dim  = 1 << (lvl + 1);
            base = ((1 << (2 * lvl + 2)) - 4) / 3;
            idx  = base + (cy & (dim - 1)) * dim + (cx & (dim - 1));
            if (item.command == CMD_ADD)
            begin
                if (cell_count[idx] == COUNT_MAX)
                    saturated = 1'b1;
                else
                begin
                    cell_count[idx] = cell_count[idx] + 1'b1;
                    if (cell_count[idx] == 1)
                        score_model = score_model + SCORE_W'(dim * dim);
                end
            end
            else
            begin
                if (cell_count[idx] == 0)
                    saturated = 1'b1;
                else
                begin
                    cell_count[idx] = cell_count[idx] - 1'b1;
                    if (cell_count[idx] == 0)
                        score_model = score_model - SCORE_W'(dim * dim);
                end
            end
            cx = cx >> 1;
            cy = cy >> 1;
        end
        outcome.score       = score_model;
        outcome.range_error = saturated;
        score_expect.push_back(outcome);
    endfunction

    // Compares one accepted response beat with the oldest prediction.
    function automatic void check_response(vps_rsp_t got);
        vps_rsp_t want;
        if (score_expect.size() == 0)
        begin
            error_count++;
            $error("response beat with no request waiting: score %0d range_error %0b",
                   got.score, got.range_error);
            return;
        end
        want = score_expect.pop_front();
        if (got.score !== want.score)
        begin
            error_count++;
            $error("score: expected %0d, got %0d", want.score, got.score);
        end
        if (got.range_error !== want.range_error)
        begin
            error_count++;
            $error("range_error: expected %0b, got %0b",
                   want.range_error, got.range_error);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. A beat is taken at an edge where valid is high and stall
    // is low; only then is it predicted, and the next one is loaded at once or
    // after a gap. A stalled beat stays put, and valid never looks at stall.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left  <= 0;
        end
        else if (req_valid && !req_stall)
        begin
            predict_score(req);
            if (!steady_flow && $urandom_range(0, 9) < 4)
            begin
                req_valid <= 1'b0;
                gap_left  <= gap_cycles() - 1;
            end
            else if (request_queue.size() != 0)
                req <= request_queue.pop_front();
            else
                req_valid <= 1'b0;
        end
        else if (!req_valid)
        begin
            if (gap_left != 0)
                gap_left <= gap_left - 1;
            else if (request_queue.size() != 0)
            begin
                req       <= request_queue.pop_front();
                req_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. It checks every accepted beat and drives stall: one
    // long hold-off when the stimulus asks for it, so that the block backs
    // up into its input, and random stalls, short or long, outside steady flow.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_response(rsp);
            if (backlog_request && !backlog_started)
            begin
                backlog_started <= 1'b1;
                hold_left       <= HOLD_CYCLES;
                rsp_stall       <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                rsp_stall  <= 1'b1;
            end
            else if (!steady_flow && $urandom_range(0, 5) == 0)
            begin
                stall_left <= gap_cycles() - 1;
                rsp_stall  <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Writes one register through a setup and an access phase, then reads it
    // back straight away. The bits above the register width are random, so
    // the block must drop them on the write. The bus is idle again when the
    // task returns.
    task automatic program_register(input logic reg_index,
                                    input logic [EXTENT_W-1:0] value);
        logic [31:0] word;
        word = ($urandom() & ~EXTENT_MASK) | 32'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_index == REG_IMAGE_WIDTH)
            width_model = value;
        else
            height_model = value;
        // Back to back read of the same register.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(value))
        begin
            cfg_error_count++;
            $error("prdata at 0x%0h: expected 0x%0h, got 0x%0h",
                   {reg_index, 2'b00}, 32'(value), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_image(input logic [EXTENT_W-1:0] w,
                             input logic [EXTENT_W-1:0] h);
        program_register(REG_IMAGE_WIDTH, w);
        program_register(REG_IMAGE_HEIGHT, h);
    endtask

    // Waits until every request has been taken and every response checked.
    // The condition is looked at on the falling edge, after all updates of
    // the rising edge have settled, and the task returns on a rising edge.
    task automatic wait_idle();
        while (request_queue.size() != 0 || req_valid || score_expect.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic queue_point(input logic cmd, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y);
        vps_req_t item;
        item.command = cmd;
        item.x_pos   = x;
        item.y_pos   = y;
        request_queue.push_back(item);
    endtask

    // A coordinate that is mostly inside the image, sometimes anywhere in
    // the 16-bit range, and sometimes right on the last-cell or the clip
    // boundary.
    function automatic logic [POS_W-1:0] pick_position(logic [EXTENT_W-1:0] extent);
        int unsigned span;
        int unsigned r;
        span = (extent == '0) ? 65536 : 16 * extent;
        if (span > 65536)
            span = 65536;
        r = $urandom_range(0, 9);
        if (r < 5)
            return POS_W'($urandom_range(0, span - 1));
        if (r < 8)
            return POS_W'($urandom());
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return POS_W'(span - 1);
            default: return POS_W'((span > 65535) ? 65535 : span);
        endcase
    endfunction

    // One random phase. Most traffic is well-formed: new points are added,
    // some are added again, and live points are removed later so counters
    // climb and fall back through one and zero. A tenth removes random points
    // that may never have been added, which can underflow some levels.
    task automatic random_phase(input int unsigned count,
                                input logic [EXTENT_W-1:0] w,
                                input logic [EXTENT_W-1:0] h,
                                input bit calm, input bit backlog);
        int unsigned i;
        int unsigned r;
        int unsigned k;
        vps_req_t    item;
        set_image(w, h);
        steady_flow <= calm;
        if (backlog)
            backlog_request <= 1'b1;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (live_points.size() == 0 || (r < 45 && live_points.size() < LIVE_MAX))
            begin
                item.command = CMD_ADD;
                item.x_pos   = pick_position(width_model);
                item.y_pos   = pick_position(height_model);
                live_points.push_back(item);
            end
            else if (r < 55)
            begin
                item = live_points[$urandom_range(0, live_points.size() - 1)];
                live_points.push_back(item);
            end
            else if (r < 90)
            begin
                k    = $urandom_range(0, live_points.size() - 1);
                item = live_points[k];
                live_points.delete(k);
                item.command = CMD_REMOVE;
            end
            else
            begin
                item.command = CMD_REMOVE;
                item.x_pos   = pick_position(width_model);
                item.y_pos   = pick_position(height_model);
            end
            request_queue.push_back(item);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset image size of 4096 by 4096 pixels.
        // A remove on the empty pyramid underflows every level.
        queue_point(CMD_REMOVE, 16'h0000, 16'h0000);
        // First add lights one cell per level, the second only counts up.
        queue_point(CMD_ADD, 16'h0000, 16'h0000);
        queue_point(CMD_ADD, 16'h0000, 16'h0000);
        // The three other corners, and two patterns that flip every bit.
        queue_point(CMD_ADD, 16'hFFFF, 16'hFFFF);
        queue_point(CMD_ADD, 16'hFFFF, 16'h0000);
        queue_point(CMD_ADD, 16'h0000, 16'hFFFF);
        queue_point(CMD_ADD, 16'h5555, 16'hAAAA);
        queue_point(CMD_ADD, 16'hAAAA, 16'h5555);
        // Just below and just on a finest-cell boundary.
        queue_point(CMD_ADD, 16'd1023, 16'd1024);
        // Drain the origin point: the last remove underflows again.
        queue_point(CMD_REMOVE, 16'h0000, 16'h0000);
        queue_point(CMD_REMOVE, 16'h0000, 16'h0000);
        queue_point(CMD_REMOVE, 16'h0000, 16'h0000);
        queue_point(CMD_REMOVE, 16'hFFFF, 16'hFFFF);
        queue_point(CMD_REMOVE, 16'hFFFF, 16'hFFFF);
        wait_idle();

        // Zero width and height: every point lands on the top cell.
        set_image('0, '0);
        queue_point(CMD_ADD, 16'd1234, 16'd4321);
        queue_point(CMD_REMOVE, 16'd1234, 16'd4321);
        queue_point(CMD_REMOVE, 16'd1234, 16'd4321);
        wait_idle();

        // One-pixel-wide image: x beyond 15 is off the image and clipped.
        set_image(13'd1, 13'd8191);
        queue_point(CMD_ADD, 16'd15, 16'h0000);
        queue_point(CMD_ADD, 16'd16, 16'hFFFF);
        queue_point(CMD_REMOVE, 16'd15, 16'h0000);
        queue_point(CMD_REMOVE, 16'd16, 16'hFFFF);
        wait_idle();

        // Random phases over a spread of image sizes, extremes included.
        // Some run without idling, and one carries the long hold-off.
        random_phase(PHASE_ITEMS, EXTENT_RESET, EXTENT_RESET, 1'b0, 1'b0);
        random_phase(PHASE_ITEMS, 13'd640, 13'd480, 1'b1, 1'b0);
        random_phase(PHASE_ITEMS, 13'd1, 13'd1, 1'b0, 1'b0);
        random_phase(PHASE_ITEMS, 13'd8191, 13'd8191, 1'b1, 1'b1);
        random_phase(PHASE_ITEMS, '0, EXTENT_RESET, 1'b0, 1'b0);
        random_phase(PHASE_ITEMS, EXTENT_W'($urandom_range(0, 8191)),
                     EXTENT_W'($urandom_range(0, 8191)), 1'b0, 1'b0);

        // Let anything stray come out before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && cfg_error_count == 0 && score_expect.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
